>>> rtl/apsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_pkg - shared types and codes of the ASCII PPM stream parser
// Result kinds, the result record and the default dimension limit.
// ----------------------------------------------------------------------------
package apsp_pkg;

  localparam int unsigned MAX_DIM_DEF = 4096;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned IMG_W   = 13;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned CHAN_W  = 8;

  localparam logic [KIND_W-1:0] KIND_HEADER    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PIXEL     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BAD_MAGIC = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BAD_SIZE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TRUNCATED = 3'd4;

  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // out_tdata width: 74 payload bits padded to whole bytes
  localparam int unsigned OUT_DATA_W = 80;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IMG_W-1:0]  image_width;
    logic [IMG_W-1:0]  image_height;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [POS_W-1:0]  column;
    logic [POS_W-1:0]  row;
    logic              image_done;
  } res_t;

endpackage

>>> rtl/ascii_ppm_stream_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_ppm_stream_parser_core - ASCII P3 image parser
// Parses one byte per beat into a header result, one result per pixel and error results.
// ----------------------------------------------------------------------------
// One file byte is taken per clock cycle, every cycle, as long as the result
// channel keeps draining. The byte is decoded in the same cycle it is
// accepted and its results (at most two, a last pixel plus a truncation
// report on end of data) are written into a four-entry result queue that
// drives the out_ port; in_tready drops only in reset or when fewer than two
// queue entries are free. Results reach out_ from the registered queue.
// in_tlast marks end of data (its byte is ignored). out_tuser carries the
// result kind and out_tlast flags the final pixel of the image.
module ascii_ppm_stream_parser_core
  import apsp_pkg::*;
#(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] byte_value
  input  logic                  in_tlast,   // end_of_data
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [12:0] image_width, [25:13] image_height, [33:26] red, [41:34] green,
  // [49:42] blue, [61:50] column, [73:62] row, [79:74] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [KIND_W-1:0]     out_tuser,  // [2:0] item_kind
  output logic                  out_tlast   // image_done
);

  localparam int unsigned DIM_W = $clog2(MAX_DIM + 2);
  localparam int unsigned ACC_W = DIM_W + 4;
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);
  localparam logic [DIM_W-1:0] DIM_SAT = DIM_W'(MAX_DIM + 1);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    PH_MAGIC0, PH_MAGIC1, PH_MAGIC1_NL, PH_SKIPLINE, PH_LINESTART, PH_COMMENT,
    PH_WIDTH, PH_SEP1, PH_HEIGHT, PH_SEP2, PH_MAXVAL, PH_PIX_SEP, PH_PIX_DIG,
    PH_DONE, PH_HALT
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [DIM_W-1:0]    hacc_r, hacc_nxt;
  logic [DIM_W-1:0]    width_r, width_nxt;
  logic [DIM_W-1:0]    height_r, height_nxt;
  logic [CHAN_W-1:0]   cacc_r, cacc_nxt;
  logic [CHAN_W-1:0]   red_r, red_nxt;
  logic [CHAN_W-1:0]   green_r, green_nxt;
  logic [1:0]          chan_r, chan_nxt;
  logic [DIM_W-1:0]    col_r, col_nxt;
  logic [DIM_W-1:0]    row_r, row_nxt;

  res_t                q_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;

  logic                in_acc, out_acc;
  logic                dig;
  logic [3:0]          dval;
  logic [DIM_W-1:0]    hdig;
  logic [11:0]         cprod;
  logic                pix_last;
  logic [DIM_W:0]      col_inc, row_inc;
  logic [DIM_W-1:0]    col_adv, row_adv;
  res_t                pix_res, res0, res1;
  logic [1:0]          n_push;

  // saturating decimal step for header numbers
  function automatic logic [DIM_W-1:0] head_step(input logic [DIM_W-1:0] acc,
                                                 input logic [3:0] d);
    logic [ACC_W-1:0] v;
    v = ACC_W'(acc) * ACC_W'(10) + ACC_W'(d);
    if (acc > DIM_MAX || v > ACC_W'(MAX_DIM)) begin
      return DIM_SAT;
    end
    return DIM_W'(v);
  endfunction

  function automatic res_t plain_res(input logic [KIND_W-1:0] k);
    res_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  assign in_tready = rst_n && (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != '0);
  assign out_acc   = out_tvalid && out_tready;

  assign dig   = (in_tdata >= CH_ZERO) && (in_tdata <= CH_NINE);
  assign dval  = dig ? 4'(in_tdata - CH_ZERO) : 4'd0;
  assign hdig  = head_step(hacc_r, dval);
  assign cprod = 12'(cacc_r) * 12'd10 + 12'(dval);

  // pixel completion: next column/row and last-pixel flag from the position counters
  assign col_inc  = {1'b0, col_r} + 1'b1;
  assign row_inc  = {1'b0, row_r} + 1'b1;
  assign pix_last = (col_inc >= {1'b0, width_r}) && (row_inc >= {1'b0, height_r});
  assign col_adv  = (col_inc >= {1'b0, width_r}) ? '0 : DIM_W'(col_inc);
  assign row_adv  = (col_inc >= {1'b0, width_r}) ? DIM_W'(row_inc) : row_r;

  always_comb begin
    pix_res            = '0;
    pix_res.kind       = KIND_PIXEL;
    pix_res.red        = red_r;
    pix_res.green      = green_r;
    pix_res.blue       = cacc_r;
    pix_res.column     = POS_W'(col_r);
    pix_res.row        = POS_W'(row_r);
    pix_res.image_done = pix_last;
  end

  always_comb begin
    phase_nxt  = phase_r;
    hacc_nxt   = hacc_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    cacc_nxt   = cacc_r;
    red_nxt    = red_r;
    green_nxt  = green_r;
    chan_nxt   = chan_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    res0       = pix_res;
    res1       = plain_res(KIND_TRUNCATED);
    n_push     = 2'd0;

    if (in_tlast) begin
      if (phase_r != PH_DONE && phase_r != PH_HALT) begin
        phase_nxt = PH_HALT;
        if (phase_r == PH_PIX_DIG && chan_r == 2'd2) begin
          // flush the pending pixel, report truncation unless it was the last
          col_nxt  = col_adv;
          row_nxt  = row_adv;
          chan_nxt = 2'd0;
          cacc_nxt = '0;
          n_push   = pix_last ? 2'd1 : 2'd2;
        end else begin
          res0   = plain_res(KIND_TRUNCATED);
          n_push = 2'd1;
        end
      end
    end else begin
      unique case (phase_r)
        PH_MAGIC0: begin
          phase_nxt = (in_tdata == CH_NL) ? PH_MAGIC1_NL : PH_MAGIC1;
        end
        PH_MAGIC1, PH_MAGIC1_NL: begin
          if (in_tdata != CH_THREE) begin
            res0      = plain_res(KIND_BAD_MAGIC);
            n_push    = 2'd1;
            phase_nxt = PH_HALT;
          end else if (phase_r == PH_MAGIC1_NL) begin
            hacc_nxt  = DIM_W'(3);
            phase_nxt = PH_WIDTH;
          end else begin
            phase_nxt = PH_SKIPLINE;
          end
        end
        PH_SKIPLINE, PH_COMMENT: begin
          if (in_tdata == CH_NL) phase_nxt = PH_LINESTART;
        end
        PH_LINESTART: begin
          if (in_tdata == CH_HASH) begin
            phase_nxt = PH_COMMENT;
          end else if (dig) begin
            hacc_nxt  = DIM_W'(dval);
            phase_nxt = PH_WIDTH;
          end else begin
            width_nxt = '0;
            phase_nxt = PH_SEP1;
          end
        end
        PH_WIDTH: begin
          if (dig) begin
            hacc_nxt = hdig;
          end else begin
            width_nxt = hacc_r;
            phase_nxt = PH_SEP1;
          end
        end
        PH_SEP1: begin
          if (dig) begin
            hacc_nxt  = DIM_W'(dval);
            phase_nxt = PH_HEIGHT;
          end
        end
        PH_HEIGHT: begin
          if (dig) begin
            hacc_nxt = hdig;
          end else begin
            height_nxt = hacc_r;
            n_push     = 2'd1;
            if (width_r == '0 || hacc_r == '0 || width_r > DIM_MAX || hacc_r > DIM_MAX)
            begin
              res0      = plain_res(KIND_BAD_SIZE);
              phase_nxt = PH_HALT;
            end else begin
              res0              = plain_res(KIND_HEADER);
              res0.image_width  = IMG_W'(width_r);
              res0.image_height = IMG_W'(hacc_r);
              phase_nxt         = PH_SEP2;
            end
          end
        end
        PH_SEP2: begin
          if (dig) phase_nxt = PH_MAXVAL;
        end
        PH_MAXVAL: begin
          if (!dig) phase_nxt = PH_PIX_SEP;
        end
        PH_PIX_SEP: begin
          if (dig) begin
            cacc_nxt  = CHAN_W'(dval);
            phase_nxt = PH_PIX_DIG;
          end
        end
        PH_PIX_DIG: begin
          if (dig) begin
            cacc_nxt = CHAN_W'(cprod);
          end else if (chan_r == 2'd0) begin
            red_nxt   = cacc_r;
            chan_nxt  = 2'd1;
            phase_nxt = PH_PIX_SEP;
          end else if (chan_r == 2'd1) begin
            green_nxt = cacc_r;
            chan_nxt  = 2'd2;
            phase_nxt = PH_PIX_SEP;
          end else begin
            col_nxt   = col_adv;
            row_nxt   = row_adv;
            chan_nxt  = 2'd0;
            cacc_nxt  = '0;
            n_push    = 2'd1;
            phase_nxt = pix_last ? PH_DONE : PH_PIX_SEP;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // parser state, advanced on every accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_MAGIC0;
      hacc_r   <= '0;
      width_r  <= '0;
      height_r <= '0;
      cacc_r   <= '0;
      red_r    <= '0;
      green_r  <= '0;
      chan_r   <= '0;
      col_r    <= '0;
      row_r    <= '0;
    end else if (in_acc) begin
      phase_r  <= phase_nxt;
      hacc_r   <= hacc_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      cacc_r   <= cacc_nxt;
      red_r    <= red_nxt;
      green_r  <= green_nxt;
      chan_r   <= chan_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_acc) wr_ptr_r <= wr_ptr_r + QPTR_W'(n_push);
      if (out_acc) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + QCNT_W'(in_acc ? n_push : 2'd0) - QCNT_W'(out_acc);
    end
  end

  // result queue payload
  always_ff @(posedge clk) begin
    if (in_acc && n_push != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (in_acc && n_push == 2'd2) begin
      q_r[wr_ptr_r + 1'b1] <= res1;
    end
  end

  res_t head;
  assign head      = q_r[rd_ptr_r];
  assign out_tuser = head.kind;
  assign out_tlast = head.image_done;
  assign out_tdata = {6'd0, head.row, head.column, head.blue, head.green, head.red,
                      head.image_height, head.image_width};

endmodule

>>> rtl/apsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_checker - port-level checks of the ASCII PPM stream parser
// Watches the byte and result channels and is bound to the parser core.
// ----------------------------------------------------------------------------
module apsp_checker
  import apsp_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [7:0]            in_tdata,
  input logic                  in_tlast,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [KIND_W-1:0]     out_tuser,
  input logic                  out_tlast
);

  // a waiting byte beat holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tlast))
    else $error("byte beat changed while waiting");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  a_header_dims: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_HEADER |->
      out_tdata[12:0] != 13'd0 && out_tdata[25:13] != 13'd0 && out_tdata[73:26] == '0)
    else $error("header with zero size or stray pixel fields");

  a_last_pixel_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == KIND_PIXEL)
    else $error("image_done on a non-pixel result");

  a_error_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_BAD_MAGIC || out_tuser == KIND_BAD_SIZE
      || out_tuser == KIND_TRUNCATED) |-> out_tdata == '0)
    else $error("error result carries payload");

endmodule

bind ascii_ppm_stream_parser_core apsp_checker u_apsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
